### src/assert_macros.svh
// Assertion macros used by the top level of the level packet decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### src/lprld_pkg.sv
// Types and constants of the level packet run-length decoder.
`default_nettype none

package lprld_pkg;

    // Input item modes
    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_BODY   = 2'd1;
    localparam logic [1:0] MODE_EMPTY  = 2'd2;

    // Escape bytes in value position
    localparam logic [7:0] ESC_CNT8      = 8'hFF;
    localparam logic [7:0] ESC_CNT16     = 8'hFE;
    localparam logic [7:0] ESC_MALFORMED = 8'hF0;  // lowest malformed escape
    localparam logic [3:0] NIBBLE_MASK   = 4'hF;

    typedef enum logic [1:0] {
        FMT_NONE   = 2'd0,
        FMT_NIBBLE = 2'd1,
        FMT_BYTE   = 2'd2
    } fmt_t;

    typedef enum logic [2:0] {
        PH_VALUE  = 3'd0,
        PH_CNT8   = 3'd1,
        PH_CNT16L = 3'd2,
        PH_CNT16H = 3'd3,
        PH_RIGHT  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  byte_value;
        logic [15:0] block_count;
    } item_t;

    typedef struct packed {
        logic [7:0]  left_level;
        logic [7:0]  right_level;
        logic [15:0] run_length;
        logic        status;
    } result_t;

    typedef struct packed {
        fmt_t       format;
        phase_t     phase;
        logic [7:0] low_count;
        logic [7:0] saved_left;
        logic       halted;
    } state_t;

endpackage

`default_nettype wire

### src/lprld_decode.sv
// Combinational decode step: one item against the current packet state.
`default_nettype none

module lprld_decode
    import lprld_pkg::*;
(
    input  state_t  state,
    input  item_t   item,
    output state_t  state_next,
    output logic    emit,
    output result_t result
);

    logic body_active;

    assign body_active = ((state.format == FMT_NIBBLE) || (state.format == FMT_BYTE))
                         && !state.halted;

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        result     = '0;
        case (item.mode)
            MODE_HEADER:
            begin
                if (item.byte_value == {6'd0, FMT_NIBBLE})
                    state_next.format = FMT_NIBBLE;
                else if (item.byte_value == {6'd0, FMT_BYTE})
                    state_next.format = FMT_BYTE;
                else
                    state_next.format = FMT_NONE;
                state_next.phase      = PH_VALUE;
                state_next.low_count  = '0;
                state_next.saved_left = '0;
                state_next.halted     = 1'b0;
            end
            MODE_BODY:
            begin
                if (body_active)
                begin
                    state_next.phase = PH_VALUE;
                    case (state.phase)
                        PH_CNT8:
                        begin
                            emit              = (item.byte_value != 8'd0);
                            result.run_length = {8'd0, item.byte_value};
                        end
                        PH_CNT16L:
                        begin
                            state_next.low_count = item.byte_value;
                            state_next.phase     = PH_CNT16H;
                        end
                        PH_CNT16H:
                        begin
                            result.run_length = {item.byte_value, state.low_count};
                            emit              = ({item.byte_value, state.low_count} != 16'd0);
                        end
                        PH_RIGHT:
                        begin
                            emit               = 1'b1;
                            result.left_level  = state.saved_left;
                            result.right_level = item.byte_value;
                            result.run_length  = 16'd1;
                        end
                        default:
                        begin
                            // value position; unused phases behave the same
                            if (item.byte_value == ESC_CNT8)
                                state_next.phase = PH_CNT8;
                            else if (item.byte_value == ESC_CNT16)
                                state_next.phase = PH_CNT16L;
                            else if (item.byte_value >= ESC_MALFORMED)
                            begin
                                state_next.halted = 1'b1;
                                emit              = 1'b1;
                                result.status     = 1'b1;
                            end
                            else if (state.format == FMT_NIBBLE)
                            begin
                                emit               = 1'b1;
                                result.left_level  = {4'd0, item.byte_value[3:0] & NIBBLE_MASK};
                                result.right_level = {4'd0, item.byte_value[7:4] & NIBBLE_MASK};
                                result.run_length  = 16'd1;
                            end
                            else
                            begin
                                state_next.saved_left = item.byte_value;
                                state_next.phase      = PH_RIGHT;
                            end
                        end
                    endcase
                end
            end
            MODE_EMPTY:
            begin
                state_next.format = FMT_NONE;
                state_next.phase  = PH_VALUE;
                state_next.halted = 1'b0;
                emit              = (item.block_count != 16'd0);
                result.run_length = item.block_count;
            end
            default:
            begin
                // unused mode: no result, state unchanged
            end
        endcase
    end

endmodule

`default_nettype wire

### src/lprld_out_stage.sv
// Result register with valid/ready handshake toward the receiver.
`default_nettype none

module lprld_out_stage
    import lprld_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     load_valid,
    input  result_t load_data,
    output logic    can_load,
    output logic    result_valid,
    input  wire     result_ready,
    output result_t result_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || result_ready;
    assign valid_next = load_valid ? 1'b1 : (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_valid)
            data_reg <= load_data;
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule

`default_nettype wire

### src/level_packet_run_length_decoder_core.sv
// Top level of the level packet run-length decoder.
//
// Usage:
//   item channel   (item_valid/item_ready/item_data): one compressed byte,
//                  header byte or empty-packet notice per transfer.
//   result channel (result_valid/result_ready/result_data): zero or one
//                  result per item; a silent run comes out as one result
//                  carrying its length, a malformed escape as status 1.
//   Timing: the item transfer loads the input register, and the result
//   register loads from it when the result side has room. Throughput:
//   one item per cycle unless the receiver stalls; the decode is a
//   short phase update between the two registers.
//   Reset (rst_n low, asynchronous) empties both registers and clears the
//   packet state: no format, value phase, not halted.
//   Receiver stall: the result register holds its transfer; one more item
//   waits in the input register, after which item_ready drops until the
//   result is taken. Items that yield nothing still wait behind a stalled
//   result so that the packet state advances strictly in order.
`default_nettype none
`include "assert_macros.svh"

module level_packet_run_length_decoder_core
    import lprld_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     item_valid,
    output logic    item_ready,
    input  item_t   item_data,
    output logic    result_valid,
    input  wire     result_ready,
    output result_t result_data
);

    // input register
    logic    stage_valid_reg;
    logic    stage_valid_next;
    item_t   stage_item_reg;

    // packet state
    state_t  state_reg;
    state_t  state_next;

    logic    emit;
    result_t step_result;
    logic    can_load;
    logic    advance;
    logic    item_take;

    // item in the input register is decoded when the result side has room
    assign advance    = stage_valid_reg && can_load;
    assign item_ready = !stage_valid_reg || advance;
    assign item_take  = item_valid && item_ready;

    assign stage_valid_next = item_take ? 1'b1 : (stage_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            stage_item_reg <= item_data;
    end

    lprld_decode u_decode (
        .state      (state_reg),
        .item       (stage_item_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (step_result)
    );

    // state moves only when the item is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.format     <= FMT_NONE;
            state_reg.phase      <= PH_VALUE;
            state_reg.low_count  <= '0;
            state_reg.saved_left <= '0;
            state_reg.halted     <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    lprld_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (advance && emit),
        .load_data    (step_result),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // halted packet: body bytes never produce a result
    `ASSERT_IMPLIES(a_halted_silent, clk, rst_n,
        advance && state_reg.halted && (stage_item_reg.mode == MODE_BODY), !emit,
        "body byte produced a result in a halted packet")

    // a pending right byte only exists in byte-pair format
    `ASSERT_IMPLIES(a_right_needs_byte_fmt, clk, rst_n,
        state_reg.phase == PH_RIGHT, state_reg.format == FMT_BYTE,
        "right-byte phase outside byte-pair format")

    // entry runs are never empty; malformed results carry no levels
    `ASSERT_IMPLIES(a_result_shape, clk, rst_n,
        result_valid,
        result_data.status ? ((result_data.run_length == 16'd0) &&
                              (result_data.left_level == 8'd0) &&
                              (result_data.right_level == 8'd0))
                           : (result_data.run_length != 16'd0),
        "result fields inconsistent with status")

    // item side only stalls when both registers are occupied and blocked
    `ASSERT_IMPLIES(a_ready_only_when_full, clk, rst_n,
        !item_ready, stage_valid_reg && result_valid && !result_ready,
        "item_ready low without a full, stalled pipeline")

endmodule

`default_nettype wire
